### hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate implication on the same edge.
`define VLP_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// Implication on the following edge.
`define VLP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

// Invariant at every edge.
`define VLP_ASSERT_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("assertion failed: invariant");

`endif

### hw/rtl/vlp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vlp_pkg;

   localparam int unsigned HEADER_BYTES_DEF = 8;
   localparam int unsigned LIMIT_W          = 32;
   localparam int unsigned POS_W            = 33;
   localparam int unsigned RSP_DEPTH        = 4;

   localparam logic [1:0] KIND_KEY  = 2'd0;
   localparam logic [1:0] KIND_VAL  = 2'd1;
   localparam logic [1:0] KIND_MARK = 2'd2;
   localparam logic [1:0] KIND_FIN  = 2'd3;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_byte;
      logic       last_in_field;
   } res_type;

   typedef struct packed {
      logic [1:0] count;
      res_type    res0;
      res_type    res1;
   } step_type;

endpackage

`default_nettype wire

### hw/rtl/vlp_parse_core.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module vlp_parse_core #(
   parameter int unsigned HEADER_BYTES = vlp_pkg::HEADER_BYTES_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         step_en,
   input  wire logic [7:0]                   data_byte,
   input  wire logic                         file_start,
   input  wire logic [vlp_pkg::LIMIT_W-1:0]  byte_limit,
   output vlp_pkg::step_type                 step_out
);
   import vlp_pkg::*;

   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_KEYLEN = 3'd1;
   localparam logic [2:0] PH_KEY    = 3'd2;
   localparam logic [2:0] PH_VALLEN = 3'd3;
   localparam logic [2:0] PH_INNER  = 3'd4;
   localparam logic [2:0] PH_STR    = 3'd5;
   localparam logic [2:0] PH_SLACK  = 3'd6;
   localparam logic [2:0] PH_DONE   = 3'd7;
   localparam logic [2:0] PH_RESET  = (HEADER_BYTES == 0) ? PH_KEYLEN : PH_HEADER;

   function automatic logic [4:0] shift_amount(input logic [2:0] sh);
      logic [4:0] amt;
      case (sh)
         3'd0:    amt = 5'd0;
         3'd1:    amt = 5'd7;
         3'd2:    amt = 5'd14;
         3'd3:    amt = 5'd21;
         3'd4:    amt = 5'd28;
         3'd5:    amt = 5'd0;
         3'd6:    amt = 5'd7;
         default: amt = 5'd14;
      endcase
      return amt;
   endfunction

   logic [POS_W-1:0]   pos_ff, pos_in, pos_eff;
   logic [2:0]         phase_ff, phase_in, phase_eff;
   logic [31:0]        acc_ff, acc_in, acc_eff, acc_take;
   logic [2:0]         sh_ff, sh_in, sh_eff;
   logic [31:0]        field_ff, field_in, field_eff, field_dec;
   logic [31:0]        slack_ff, slack_in, slack_eff, slack_dec;
   logic               fin_pre;
   logic [POS_W:0]     nxt, lim_ext;
   logic               rec_fin, slk_fin, over, bad, more;
   logic               do_fin, do_rec, do_slk;
   logic               data_em, mark_em, data_last;
   logic [1:0]         data_kind;
   res_type            first_res, fin_res;

   always_comb begin
      pos_eff   = pos_ff;
      phase_eff = phase_ff;
      acc_eff   = acc_ff;
      sh_eff    = sh_ff;
      field_eff = field_ff;
      slack_eff = slack_ff;
      fin_pre   = 1'b0;
      if (file_start) begin
         pos_eff   = '0;
         acc_eff   = '0;
         sh_eff    = '0;
         field_eff = '0;
         slack_eff = '0;
         if (HEADER_BYTES == 0) begin
            if (byte_limit == '0) begin
               fin_pre   = 1'b1;
               phase_eff = PH_DONE;
            end else begin
               phase_eff = PH_KEYLEN;
            end
         end else begin
            phase_eff = PH_HEADER;
         end
      end
   end

   assign nxt       = {1'b0, pos_eff} + {{POS_W{1'b0}}, 1'b1};
   assign lim_ext   = {{(POS_W + 1 - LIMIT_W){1'b0}}, byte_limit};
   assign rec_fin   = nxt >= lim_ext;
   assign acc_take  = acc_eff | ({25'd0, data_byte[6:0]} << shift_amount(sh_eff));
   assign more      = data_byte[7];
   assign bad       = data_byte[7] && (sh_eff >= 3'd4);
   assign over      = (nxt <= lim_ext) && ({2'b00, acc_take} > (lim_ext - nxt));
   assign slack_dec = (slack_eff != '0) ? slack_eff - 32'd1 : slack_eff;
   assign field_dec = field_eff - 32'd1;
   assign slk_fin   = ({1'b0, nxt} + {3'b000, slack_dec}) >= {1'b0, lim_ext};

   always_comb begin
      pos_in    = (pos_eff == {POS_W{1'b1}}) ? pos_eff : pos_eff + {{(POS_W-1){1'b0}}, 1'b1};
      phase_in  = phase_eff;
      acc_in    = acc_eff;
      sh_in     = sh_eff;
      field_in  = field_eff;
      slack_in  = slack_eff;
      do_fin    = 1'b0;
      do_rec    = 1'b0;
      do_slk    = 1'b0;
      data_em   = 1'b0;
      data_kind = KIND_KEY;
      data_last = 1'b0;
      mark_em   = 1'b0;
      case (phase_eff)
         PH_HEADER: begin
            if (nxt >= (POS_W + 1)'(HEADER_BYTES)) do_rec = 1'b1;
         end
         PH_KEYLEN: begin
            acc_in = acc_take;
            if (more) sh_in = sh_eff + 3'd1;
            if (bad) begin
               do_fin = 1'b1;
            end else if (more) begin
               do_fin = rec_fin;
            end else if (acc_take == '0 || over) begin
               do_fin = 1'b1;
            end else begin
               phase_in = PH_KEY;
               field_in = acc_take;
            end
         end
         PH_KEY: begin
            data_em   = 1'b1;
            data_kind = KIND_KEY;
            data_last = (field_eff == 32'd1);
            field_in  = field_dec;
            if (field_dec == '0) begin
               if (rec_fin) begin
                  do_fin = 1'b1;
               end else begin
                  phase_in = PH_VALLEN;
                  acc_in   = '0;
                  sh_in    = '0;
               end
            end
         end
         PH_VALLEN: begin
            acc_in = acc_take;
            if (more) sh_in = sh_eff + 3'd1;
            if (bad) begin
               do_fin = 1'b1;
            end else if (more) begin
               do_fin = rec_fin;
            end else if (acc_take == '0) begin
               mark_em = 1'b1;
               do_rec  = 1'b1;
            end else if (rec_fin) begin
               mark_em = 1'b1;
               do_fin  = 1'b1;
            end else begin
               phase_in = PH_INNER;
               acc_in   = '0;
               sh_in    = '0;
               slack_in = acc_take;
            end
         end
         PH_INNER: begin
            slack_in = slack_dec;
            acc_in   = acc_take;
            if (more) sh_in = sh_eff + 3'd1;
            if (bad) begin
               mark_em = 1'b1;
               do_slk  = 1'b1;
            end else if (more) begin
               mark_em = rec_fin;
               do_fin  = rec_fin;
            end else if (acc_take == '0) begin
               mark_em = 1'b1;
               do_slk  = 1'b1;
            end else if (over) begin
               mark_em = 1'b1;
               do_fin  = 1'b1;
            end else begin
               phase_in = PH_STR;
               field_in = acc_take;
            end
         end
         PH_STR: begin
            slack_in  = slack_dec;
            data_em   = 1'b1;
            data_kind = KIND_VAL;
            data_last = (field_eff == 32'd1);
            field_in  = field_dec;
            if (field_dec == '0) do_slk = 1'b1;
         end
         PH_SLACK: begin
            slack_in = slack_dec;
            if (slack_dec == '0) do_rec = 1'b1;
         end
         default: begin
         end
      endcase
      if (do_slk) begin
         if (slack_dec == '0) begin
            do_rec = 1'b1;
         end else if (slk_fin) begin
            do_fin = 1'b1;
         end else begin
            phase_in = PH_SLACK;
         end
      end
      if (do_rec) begin
         if (rec_fin) begin
            do_fin = 1'b1;
         end else begin
            phase_in = PH_KEYLEN;
            acc_in   = '0;
            sh_in    = '0;
         end
      end
      if (do_fin) phase_in = PH_DONE;
   end

   always_comb begin
      fin_res.kind          = KIND_FIN;
      fin_res.out_byte      = 8'd0;
      fin_res.last_in_field = 1'b0;
      if (data_em) begin
         first_res.kind          = data_kind;
         first_res.out_byte      = data_byte;
         first_res.last_in_field = data_last;
      end else begin
         first_res.kind          = KIND_MARK;
         first_res.out_byte      = 8'd0;
         first_res.last_in_field = 1'b0;
      end
      step_out.res0 = fin_res;
      step_out.res1 = fin_res;
      if (data_em || mark_em) begin
         step_out.res0  = first_res;
         step_out.count = (do_fin || fin_pre) ? 2'd2 : 2'd1;
      end else begin
         step_out.count = (do_fin || fin_pre) ? 2'd1 : 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         phase_ff <= PH_RESET;
         acc_ff   <= '0;
         sh_ff    <= '0;
         field_ff <= '0;
         slack_ff <= '0;
      end else if (step_en) begin
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         sh_ff    <= sh_in;
         field_ff <= field_in;
         slack_ff <= slack_in;
      end
   end

   `VLP_ASSERT_IMPLY(a_done_silent, step_en && phase_ff == PH_DONE && !file_start, step_out.count == 2'd0)
   `VLP_ASSERT_IMPLY(a_pair_ends, step_en && step_out.count == 2'd2, step_out.res1.kind == KIND_FIN && phase_in == PH_DONE)

endmodule

`default_nettype wire

### hw/rtl/vlp_rsp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module vlp_rsp_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_en,
   input  wire vlp_pkg::step_type push_data,
   output logic                   room,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output vlp_pkg::res_type       rsp_data
);
   import vlp_pkg::*;

   localparam int unsigned PTR_W = $clog2(RSP_DEPTH);
   localparam int unsigned CNT_W = $clog2(RSP_DEPTH + 1);

   res_type            mem_ff [RSP_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, wr_ptr_p1;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [1:0]         push_n;
   logic               pop;

   assign push_n    = push_en ? push_data.count : 2'd0;
   assign pop       = rsp_valid && rsp_ready;
   assign wr_ptr_p1 = wr_ptr_ff + PTR_W'(1);
   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push_n);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign cnt_in    = cnt_ff + CNT_W'(push_n) - CNT_W'(pop);
   assign room      = cnt_ff <= CNT_W'(RSP_DEPTH - 2);
   assign rsp_valid = cnt_ff != '0;
   assign rsp_data  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) mem_ff[wr_ptr_ff] <= push_data.res0;
      if (push_n == 2'd2) mem_ff[wr_ptr_p1] <= push_data.res1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   `VLP_ASSERT_ALWAYS(a_no_overflow, cnt_ff <= CNT_W'(RSP_DEPTH))
   `VLP_ASSERT_IMPLY(a_push_fits, push_n != 2'd0, room)

endmodule

`default_nettype wire

### hw/rtl/varint_length_prefixed_record_parser_unit.sv
// Each input passes the input register, then the response queue (four entries), before
// its first result reaches rsp_. Throughput: one byte per cycle while the queue has room;
// these two decouple the sides, and a byte that yields two results drains one at a time.
// Reset (synchronous, active high) clears byte_limit to 0, empties the queue and
// puts the parser at byte 0 of a new file.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module varint_length_prefixed_record_parser_unit #(
   parameter int unsigned HEADER_BYTES = vlp_pkg::HEADER_BYTES_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [7:0]                   req_data_byte,
   input  wire logic                         req_file_start,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [1:0]                        rsp_kind,
   output logic [7:0]                        rsp_out_byte,
   output logic                              rsp_last_in_field,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [vlp_pkg::LIMIT_W-1:0]  csr_byte_limit
);
   import vlp_pkg::*;

   logic                stage_valid_ff, stage_valid_in;
   logic [7:0]          stage_byte_ff;
   logic                stage_start_ff;
   logic [LIMIT_W-1:0]  limit_ff;
   logic                room, fire, req_take;
   step_type            step_out;
   res_type             head;

   assign csr_ready      = 1'b1;
   assign fire           = stage_valid_ff && room;
   assign req_ready      = !stage_valid_ff || room;
   assign req_take       = req_valid && req_ready;
   assign stage_valid_in = req_take || (stage_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         limit_ff       <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         if (csr_valid) limit_ff <= csr_byte_limit;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_byte_ff  <= req_data_byte;
         stage_start_ff <= req_file_start;
      end
   end

   vlp_parse_core #(
      .HEADER_BYTES (HEADER_BYTES)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step_en    (fire),
      .data_byte  (stage_byte_ff),
      .file_start (stage_start_ff),
      .byte_limit (limit_ff),
      .step_out   (step_out)
   );

   vlp_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_en   (fire),
      .push_data (step_out),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (head)
   );

   assign rsp_kind          = head.kind;
   assign rsp_out_byte      = head.out_byte;
   assign rsp_last_in_field = head.last_in_field;

   `VLP_ASSERT_NEXT(a_stage_hold, stage_valid_ff && !fire, stage_valid_ff && $stable(stage_byte_ff) && $stable(stage_start_ff))

endmodule

`default_nettype wire
